FILE: hdl/ocp_pkg.sv
// ----------------------------------------------------------------------------
// ocp_pkg
// Shared constants, types and the arctangent table of the orbit camera unit.
// ----------------------------------------------------------------------------
package ocp_pkg;

  localparam int POSITION_BITS_DEF = 24;
  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int MAX_STEPS         = 24;

  localparam int TURN_UNITS = 4000;
  localparam int QUAD_UNITS = 1000;
  localparam int ELEV_MIN   = 1000;
  localparam int ELEV_MAX   = 1500;
  localparam int FIRST_DX   = 700;
  localparam int FIRST_DY   = 500;
  localparam int RAD_PER_UNIT_Q30 = 1686630;
  localparam int CORDIC_START     = 19898;

  localparam int DIST_W = 23;
  localparam int REG_W  = 24;
  localparam int FLD_W  = 24;
  localparam int DELTA_W = 12;
  localparam int AZ_W   = 12;
  localparam int EL_W   = 11;
  localparam int Z_W    = 32;
  localparam int XY_W   = 18;
  localparam int TRIG_W = 16;
  localparam int STEP_W = 5;

  localparam logic [1:0] REG_DISTANCE = 2'd0;
  localparam logic [1:0] REG_OFFSET   = 2'd1;
  localparam logic [1:0] REG_INIT_H   = 2'd2;

  // shared multiplier operand selection
  localparam logic [1:0] MUL_DSE = 2'd0;
  localparam logic [1:0] MUL_X   = 2'd1;
  localparam logic [1:0] MUL_Z   = 2'd2;
  localparam logic [1:0] MUL_Y   = 2'd3;

  typedef struct packed {
    logic start;
    logic load_az;
    logic load_el;
    logic cordic_go;
    logic [1:0] mul_sel;
    logic mul_go;
    logic finish;
  } ocp_cmd_t;

  typedef struct packed {
    logic cordic_done;
  } ocp_sts_t;

  function automatic logic signed [Z_W-1:0] atan_q30(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] r;
    unique case (i)
      5'd0: r = 32'sd843314857;  5'd1: r = 32'sd497837829;
      5'd2: r = 32'sd263043837;  5'd3: r = 32'sd133525159;
      5'd4: r = 32'sd67021687;   5'd5: r = 32'sd33543516;
      5'd6: r = 32'sd16775851;   5'd7: r = 32'sd8388437;
      5'd8: r = 32'sd4194283;    5'd9: r = 32'sd2097149;
      default: r = (i < 5'd24) ? (32'sd1 <<< (5'd30 - i)) : 32'sd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/orbit_camera_position_unit.sv
// The block takes a new item only after the result of the last one is taken;
// each item runs two CORDIC passes in turn and four multiply steps.
// Reset: synchronous active low; angles, freeze and start flags cleared,
// camera held at (0, 0, 0), registers at their reset values.
// ----------------------------------------------------------------------------
// orbit_camera_position_unit
// Orbit camera position and view vector from mouse deltas and a target.
// ----------------------------------------------------------------------------
module orbit_camera_position_unit import ocp_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [95:0] in_tdata,   // mouse_dx, mouse_dy, target_x, target_y, target_z
  input  logic in_tuser,          // freeze_key_pushed
  output logic out_tvalid,
  input  logic out_tready,
  output logic [143:0] out_tdata, // cam_x, cam_y, cam_z, view_x, view_y, view_z
  output logic out_tuser,         // is_frozen
  input  logic cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [REG_W-1:0] cfg_wdata
);

  ocp_cmd_t cmd;
  ocp_sts_t sts;

  ocp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .cmd(cmd), .sts(sts)
  );

  ocp_datapath #(.POSITION_BITS(POSITION_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_data(in_tdata), .in_freeze(in_tuser),
    .cfg_we(cfg_we), .cfg_idx(cfg_addr), .cfg_data(cfg_wdata),
    .res_data(out_tdata), .res_frozen(out_tuser)
  );

endmodule

FILE: hdl/ocp_cordic.sv
// ----------------------------------------------------------------------------
// ocp_cordic
// Iterative rotation CORDIC, one step per cycle, quadrant mapped Q1.15 out.
// ----------------------------------------------------------------------------
module ocp_cordic import ocp_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic go,
  input  logic [AZ_W-1:0] angle,
  output logic done,
  output logic signed [TRIG_W:0] cos_o,
  output logic signed [TRIG_W:0] sin_o
);

  localparam int TO_W = TRIG_W + 1;

  logic signed [XY_W-1:0] x_r, y_r;
  logic signed [Z_W-1:0]  z_r;
  logic [1:0]  q_r;
  logic [STEP_W-1:0] i_r;
  logic busy_r, done_r;
  logic [1:0] q;
  logic [AZ_W-1:0] rem;
  logic signed [TRIG_W:0] xc, yc;

  always_comb begin
    if (angle >= AZ_W'(3*QUAD_UNITS)) begin
      q = 2'd3; rem = angle - AZ_W'(3*QUAD_UNITS);
    end else if (angle >= AZ_W'(2*QUAD_UNITS)) begin
      q = 2'd2; rem = angle - AZ_W'(2*QUAD_UNITS);
    end else if (angle >= AZ_W'(QUAD_UNITS)) begin
      q = 2'd1; rem = angle - AZ_W'(QUAD_UNITS);
    end else begin
      q = 2'd0; rem = angle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        i_r <= '0;
        q_r <= q;
        x_r <= XY_W'(CORDIC_START);
        y_r <= '0;
        z_r <= Z_W'($signed({1'b0, rem}) * $signed(Z_W'(RAD_PER_UNIT_Q30)));
      end else if (busy_r) begin
        if (z_r >= 0) begin
          x_r <= x_r - (y_r >>> i_r);
          y_r <= y_r + (x_r >>> i_r);
          z_r <= z_r - atan_q30(i_r);
        end else begin
          x_r <= x_r + (y_r >>> i_r);
          y_r <= y_r - (x_r >>> i_r);
          z_r <= z_r + atan_q30(i_r);
        end
        i_r <= i_r + 1'b1;
        if (i_r == STEP_W'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign xc = (x_r > 32767) ? TO_W'(32767) : (x_r < -32768) ? TO_W'(-32768) : TO_W'(x_r);
  assign yc = (y_r > 32767) ? TO_W'(32767) : (y_r < -32768) ? TO_W'(-32768) : TO_W'(y_r);

  // negation of -32768 must reach +32768, so outputs carry one extra bit
  always_comb begin
    unique case (q_r)
      2'd0: begin cos_o = xc; sin_o = yc; end
      2'd1: begin cos_o = -yc; sin_o = xc; end
      2'd2: begin cos_o = -xc; sin_o = -yc; end
      default: begin cos_o = yc; sin_o = -xc; end
    endcase
  end

  assign done = done_r;

endmodule

FILE: hdl/ocp_datapath.sv
// ----------------------------------------------------------------------------
// ocp_datapath
// Angle accumulators, CORDIC, shared multiplier, saturating sums, result.
// ----------------------------------------------------------------------------
module ocp_datapath import ocp_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  ocp_cmd_t cmd,
  output ocp_sts_t sts,
  input  logic [95:0] in_data,
  input  logic in_freeze,
  input  logic cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [REG_W-1:0] cfg_data,
  output logic [143:0] res_data,
  output logic res_frozen
);

  localparam int P = POSITION_BITS;
  localparam int W = 64;
  localparam int MA_W = DIST_W + TRIG_W + 3;
  localparam int PM_W = MA_W + TRIG_W + 1;

  logic [DIST_W-1:0] dist_r;
  logic signed [REG_W-1:0] off_r;
  logic [AZ_W-1:0] az_r;
  logic [EL_W-1:0] el_r;
  logic signed [P-1:0] pos_r [3];
  logic signed [P-1:0] tgt_r [3];
  logic frozen_r, started_r;
  logic signed [TRIG_W:0] ca_r, sa_r, ce_r, se_r;
  logic signed [MA_W-1:0] dse_r;
  logic signed [W-1:0] dce_r, sca_r, ssa_r;
  logic signed [DELTA_W-1:0] dx, dy;
  logic signed [DELTA_W+1:0] az_s, el_s;
  logic [AZ_W-1:0] az_new;
  logic [EL_W-1:0] el_new;
  logic cgo;
  logic [AZ_W-1:0] cang;
  logic cdone;
  logic signed [TRIG_W:0] cc, cs;
  logic signed [MA_W-1:0] ma;
  logic signed [TRIG_W:0] mb;
  logic signed [PM_W-1:0] mp;
  logic signed [W-1:0] rx, ry, rz;
  logic signed [P-1:0] px, py, pz;
  logic signed [P-1:0] vx, vy, vz;
  logic fz_next;

  function automatic logic signed [P-1:0] sat(input logic signed [W-1:0] v);
    logic signed [W-1:0] hi, lo;
    hi = (W'(1) <<< (P-1)) - 1;
    lo = -hi - 1;
    if (v > hi) return P'(hi);
    if (v < lo) return P'(lo);
    return P'(v);
  endfunction

  assign dx = started_r ? $signed(in_data[11:0]) : DELTA_W'(FIRST_DX);
  assign dy = started_r ? $signed(in_data[23:12]) : DELTA_W'(FIRST_DY);
  assign fz_next = frozen_r ^ in_freeze;

  always_comb begin
    az_s = $signed({2'b0, az_r}) + dx;
    if (az_s < 0) az_new = AZ_W'(az_s + TURN_UNITS);
    else if (az_s >= TURN_UNITS) az_new = AZ_W'(az_s - TURN_UNITS);
    else az_new = AZ_W'(az_s);
    el_s = $signed({3'b0, el_r}) + dy;
    if (el_s < ELEV_MIN) el_new = EL_W'(ELEV_MIN);
    else if (el_s > ELEV_MAX) el_new = EL_W'(ELEV_MAX);
    else el_new = EL_W'(el_s);
  end

  assign cang = cmd.load_el ? {1'b0, el_r} : az_r;
  assign cgo = cmd.cordic_go;

  ocp_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .go(cgo), .angle(cang),
    .done(cdone), .cos_o(cc), .sin_o(cs)
  );
  assign sts.cordic_done = cdone;

  // one multiply per step: d*se, dse*ca, dse*sa, d*ce
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_DSE: begin ma = MA_W'(signed'({1'b0, dist_r})); mb = se_r; end
      MUL_X:   begin ma = dse_r; mb = ca_r; end
      MUL_Z:   begin ma = dse_r; mb = sa_r; end
      default: begin ma = MA_W'(signed'({1'b0, dist_r})); mb = ce_r; end
    endcase
  end

  assign mp = PM_W'(ma) * PM_W'(mb);

  always_comb begin
    rx = (sca_r + (W'(1) <<< 29)) >>> 30;
    ry = ((-dce_r) + (W'(1) <<< 14)) >>> 15;
    rz = ((-ssa_r) + (W'(1) <<< 29)) >>> 30;
    px = sat(rx + W'(tgt_r[0]));
    py = sat(ry + W'(tgt_r[1]));
    pz = sat(rz + W'(tgt_r[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= DIST_W'(256000);
      off_r <= '0;
      az_r <= '0;
      el_r <= '0;
      frozen_r <= 1'b0;
      started_r <= 1'b0;
      pos_r[0] <= '0;
      pos_r[1] <= '0;
      pos_r[2] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_DISTANCE: dist_r <= cfg_data[DIST_W-1:0];
          REG_OFFSET: off_r <= $signed(cfg_data);
          REG_INIT_H: begin
            if (!started_r) pos_r[1] <= sat(W'($signed(cfg_data)));
          end
          default: ;
        endcase
      end
      if (cmd.start) begin
        started_r <= 1'b1;
        frozen_r <= fz_next;
        tgt_r[0] <= sat(W'($signed(in_data[47:24])));
        tgt_r[2] <= sat(W'($signed(in_data[95:72])));
        if (!fz_next) begin
          az_r <= az_new;
          el_r <= el_new;
          tgt_r[1] <= sat(W'($signed(in_data[71:48])) + W'(off_r));
        end else begin
          tgt_r[1] <= sat(W'($signed(in_data[71:48])));
        end
      end
      if (cdone && cmd.load_az) begin
        ca_r <= cc; sa_r <= cs;
      end
      if (cdone && cmd.load_el) begin
        ce_r <= cc; se_r <= cs;
      end
      if (cmd.mul_go) begin
        unique case (cmd.mul_sel)
          MUL_DSE: dse_r <= MA_W'(mp);
          MUL_X: sca_r <= W'(mp);
          MUL_Z: ssa_r <= W'(mp);
          default: dce_r <= W'(mp);
        endcase
      end
      if (cmd.finish && !frozen_r) begin
        pos_r[0] <= px;
        pos_r[1] <= py;
        pos_r[2] <= pz;
      end
    end
  end

  assign vx = sat(W'(tgt_r[0]) - W'(pos_r[0]));
  assign vy = sat(W'(tgt_r[1]) - W'(pos_r[1]));
  assign vz = sat(W'(tgt_r[2]) - W'(pos_r[2]));

  assign res_data = {FLD_W'(vz), FLD_W'(vy), FLD_W'(vx),
                     FLD_W'(pos_r[2]), FLD_W'(pos_r[1]), FLD_W'(pos_r[0])};
  assign res_frozen = frozen_r;

endmodule

FILE: hdl/ocp_ctrl.sv
// ----------------------------------------------------------------------------
// ocp_ctrl
// Sequencer: two CORDIC runs, product steps, result hold.
// ----------------------------------------------------------------------------
module ocp_ctrl import ocp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  output ocp_cmd_t cmd,
  input  ocp_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE, S_AZ_GO, S_AZ, S_EL_GO, S_EL, S_M0, S_M1, S_M2, S_M3, S_FIN, S_OUT
  } state_t;

  state_t state_r;
  logic ovalid_r;

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;

  always_comb begin
    cmd = '0;
    cmd.start = in_tvalid && in_tready;
    unique case (state_r)
      S_AZ_GO: cmd.cordic_go = 1'b1;
      S_AZ: cmd.load_az = 1'b1;
      S_EL_GO: begin cmd.cordic_go = 1'b1; cmd.load_el = 1'b1; end
      S_EL: cmd.load_el = 1'b1;
      S_M0: begin cmd.mul_sel = MUL_DSE; cmd.mul_go = 1'b1; end
      S_M1: begin cmd.mul_sel = MUL_X; cmd.mul_go = 1'b1; end
      S_M2: begin cmd.mul_sel = MUL_Z; cmd.mul_go = 1'b1; end
      S_M3: begin cmd.mul_sel = MUL_Y; cmd.mul_go = 1'b1; end
      S_FIN: cmd.finish = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_tvalid) state_r <= S_AZ_GO;
        S_AZ_GO: state_r <= S_AZ;
        S_AZ: if (sts.cordic_done) state_r <= S_EL_GO;
        S_EL_GO: state_r <= S_EL;
        S_EL: if (sts.cordic_done) state_r <= S_M0;
        S_M0: state_r <= S_M1;
        S_M1: state_r <= S_M2;
        S_M2: state_r <= S_M3;
        S_M3: state_r <= S_FIN;
        S_FIN: begin state_r <= S_OUT; ovalid_r <= 1'b1; end
        S_OUT: if (out_tready) begin ovalid_r <= 1'b0; state_r <= S_IDLE; end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> state_r == S_OUT) else $error("valid outside output state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("accept while busy");
  a_fin_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_tvalid) else $error("missing result");
`endif

endmodule

FILE: sim/orbit_camera_position_unit_tb.sv
// ----------------------------------------------------------------------------
// orbit_camera_position_unit_tb
// Self-checking bench for the orbit camera unit. It streams mouse deltas,
// targets and freeze pushes into the block under random sender and receiver
// stalls. A built-in camera model (angle accumulators, CORDIC, saturating
// Q16.8 arithmetic) predicts every result, and each one is checked field by
// field. The orbit registers are reprogrammed between phases.
// ----------------------------------------------------------------------------
module orbit_camera_position_unit_tb;
  import ocp_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 2 * CORDIC_STEPS_DEF + 20;

  typedef struct packed {
    logic [2:0][23:0] pos;
    logic [2:0][23:0] vw;
    logic             frz;
  } camera_view_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [143:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [REG_W-1:0] cfg_wdata = '0;

  always #4 clk = ~clk;

  orbit_camera_position_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // camera model state
  longint orbit_dist, height_offset, start_height;
  int az_acc, el_acc;
  longint cam_pos [3];
  bit frozen, started;

  camera_view_t pending_views [$];
  int errors = 0;
  int checked = 0;
  int frozen_seen = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;
  logic hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  const longint atan_tab [16] = '{843314857, 497837829, 263043837, 133525159,
    67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768};

  function automatic longint sat_q16(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint round_q(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic void sin_cos(input int a, output longint c, output longint s);
    int q;
    longint x, y, z, xs, ys;
    q = (a / QUAD_UNITS) % 4;
    z = longint'(a % QUAD_UNITS) * RAD_PER_UNIT_Q30;
    x = CORDIC_START;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_tab[i];
      end else begin
        x += ys; y -= xs; z += atan_tab[i];
      end
    end
    if (x > 32767) x = 32767;
    if (x < -32768) x = -32768;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    case (q)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic camera_view_t next_camera(input logic [95:0] d, input logic push);
    camera_view_t r;
    longint dx, dy, azn, eln, ca, sa, ce, se, vtmp;
    longint tgt [3];
    dx = longint'($signed(d[11:0]));
    dy = longint'($signed(d[23:12]));
    for (int k = 0; k < 3; k++) tgt[k] = longint'($signed(d[24 + 24*k +: 24]));
    if (!started) begin
      dx = FIRST_DX;
      dy = FIRST_DY;
      started = 1'b1;
    end
    if (push) frozen = !frozen;
    if (!frozen) begin
      azn = (az_acc + dx) % TURN_UNITS;
      if (azn < 0) azn += TURN_UNITS;
      eln = el_acc + dy;
      if (eln < ELEV_MIN) eln = ELEV_MIN;
      if (eln > ELEV_MAX) eln = ELEV_MAX;
      az_acc = int'(azn);
      el_acc = int'(eln);
      tgt[1] = sat_q16(tgt[1] + height_offset);
      sin_cos(az_acc, ca, sa);
      sin_cos(el_acc, ce, se);
      cam_pos[0] = sat_q16(round_q(orbit_dist * (se * ca), 30) + tgt[0]);
      cam_pos[1] = sat_q16(round_q(-(orbit_dist * ce), 15) + tgt[1]);
      cam_pos[2] = sat_q16(round_q(-(orbit_dist * (se * sa)), 30) + tgt[2]);
    end
    for (int k = 0; k < 3; k++) begin
      r.pos[k] = cam_pos[k][23:0];
      vtmp = sat_q16(tgt[k] - cam_pos[k]);
      r.vw[k] = vtmp[23:0];
    end
    r.frz = frozen;
    return r;
  endfunction

  // receiver with random stall and long hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= 400;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    camera_view_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.pos = out_tdata[71:0];
      got.vw = out_tdata[143:72];
      got.frz = out_tuser;
      if (pending_views.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_views.pop_front();
        checked++;
        if (want.frz) frozen_seen++;
        for (int k = 0; k < 3; k++) begin
          if (got.pos[k] !== want.pos[k]) begin
            $display("%0t: cam[%0d] expected %h actual %h", $time, k, want.pos[k], got.pos[k]);
            errors++;
          end
          if (got.vw[k] !== want.vw[k]) begin
            $display("%0t: view[%0d] expected %h actual %h", $time, k, want.vw[k], got.vw[k]);
            errors++;
          end
        end
        if (got.frz !== want.frz) begin
          $display("%0t: is_frozen expected %b actual %b", $time, want.frz, got.frz);
          errors++;
        end
      end
    end
  end

  // watchdog on transfers
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("orbit_camera_position_unit_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic signed [11:0] dx, input logic signed [11:0] dy,
                           input logic [23:0] tx, input logic [23:0] ty,
                           input logic [23:0] tz, input logic push);
    logic [95:0] d;
    d = {tz, ty, tx, dy, dx};
    in_tdata <= d;
    in_tuser <= push;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_views.push_back(next_camera(d, push));
    if ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_DISTANCE: orbit_dist = val[22:0];
      REG_OFFSET: height_offset = longint'($signed(val));
      REG_INIT_H: begin
        start_height = longint'($signed(val));
        if (!started) cam_pos[1] = start_height;
      end
      default: ;
    endcase
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($signed(12'($urandom)));
      2: return $urandom_range(1) ? 24'h7fffff : 24'h800000;
      default: return 24'($signed(16'($urandom)));
    endcase
  endfunction

  function automatic logic [11:0] rand_delta();
    case ($urandom_range(3))
      0: return 12'($urandom);
      1: return $urandom_range(1) ? 12'h7ff : 12'h800;
      default: return 12'($signed(7'($urandom)));
    endcase
  endfunction

  task automatic test_reset_and_first_item();
    write_reg(REG_INIT_H, 24'h123456);
    write_reg(REG_UNUSED, 24'hffffff);
    send_item(12'h7ff, 12'h800, 24'h000100, 24'h000200, 24'h000300, 1'b0);
    wait_drain();
    write_reg(REG_INIT_H, 24'h800000);
  endtask

  task automatic test_directed();
    send_item(12'h800, 12'h800, 24'h7fffff, 24'h7fffff, 24'h7fffff, 1'b0);
    send_item(12'h7ff, 12'h7ff, 24'h800000, 24'h800000, 24'h800000, 1'b0);
    send_item(12'h000, 12'h000, 24'h000000, 24'h000000, 24'h000000, 1'b0);
    send_item(-12'sd1, 12'h7ff, 24'h0, 24'h0, 24'h0, 1'b0);
    send_item(12'h7ff, -12'sd600, 24'hfffff0, 24'h000010, 24'h7ff000, 1'b0);
    send_item(12'h123, 12'h045, 24'h111111, 24'h222222, 24'h333333, 1'b1);
    send_item(12'h7ff, 12'h7ff, 24'h444444, 24'h555555, 24'h666666, 1'b0);
    send_item(12'h100, 12'h010, 24'h7fffff, 24'h800000, 24'h7fffff, 1'b1);
    send_item(12'h3e8, 12'h064, 24'h000000, 24'h7fffff, 24'h000000, 1'b0);
    send_item(12'h3e8, 12'h000, 24'h000000, 24'h000000, 24'h000000, 1'b0);
    send_item(12'h3e8, 12'h000, 24'h000000, 24'h000000, 24'h000000, 1'b0);
    send_item(12'h3e8, 12'h000, 24'h000000, 24'h000000, 24'h000000, 1'b1);
    send_item(12'h000, 12'h000, 24'h000000, 24'h000000, 24'h000000, 1'b1);
    wait_drain();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_DISTANCE, 24'hffffff);
    write_reg(REG_OFFSET, 24'h800000);
    for (int i = 0; i < 6; i++) send_item(rand_delta(), rand_delta(), rand_coord(),
                                          rand_coord(), rand_coord(), 1'b0);
    wait_drain();
    write_reg(REG_DISTANCE, 24'h000000);
    write_reg(REG_OFFSET, 24'h7fffff);
    for (int i = 0; i < 6; i++) send_item(rand_delta(), rand_delta(), rand_coord(),
                                          rand_coord(), rand_coord(), 1'b0);
    wait_drain();
  endtask

  task automatic random_phase(input int n, input int gap, input int stall);
    send_gap_pct = gap;
    stall_pct = stall;
    write_reg(REG_DISTANCE, $urandom_range(1) ? 24'($urandom_range(4096)) : 24'($urandom));
    write_reg(REG_OFFSET, rand_coord());
    write_reg(REG_INIT_H, 24'($urandom));
    for (int i = 0; i < n; i++)
      send_item(rand_delta(), rand_delta(), rand_coord(), rand_coord(), rand_coord(),
                $urandom_range(9) == 0);
    wait_drain();
  endtask

  task automatic test_backpressure();
    stall_pct = 0;
    send_gap_pct = 0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int i = 0; i < 20; i++)
      send_item(rand_delta(), rand_delta(), rand_coord(), rand_coord(), rand_coord(),
                $urandom_range(5) == 0);
    wait_drain();
  endtask

  initial begin
    orbit_dist = 256000;
    height_offset = 0;
    start_height = 0;
    az_acc = 0;
    el_acc = 0;
    cam_pos = '{0, 0, 0};
    frozen = 1'b0;
    started = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_and_first_item();
    test_directed();
    test_register_extremes();
    random_phase(290, 7, 66);
    random_phase(290, 66, 7);
    random_phase(290, 0, 0);
    test_backpressure();
    $display("checked %0d camera results, %0d of them frozen", checked, frozen_seen);
    $display("covered register extremes, freeze toggles, stalls and a long output hold");
    if (errors == 0) begin
      $display("orbit_camera_position_unit_tb: clean");
    end else begin
      $display("orbit_camera_position_unit_tb: errors");
    end
    $finish;
  end

endmodule
